@@ src/xydt_pkg.sv @@
// Shared types and constants for the x^y / y^x divisibility test block.
package xydt_pkg;

  localparam int PRIME_BITS = 62;
  localparam int TERM_BITS  = 32;
  localparam int MUL_STEPS  = PRIME_BITS;
  localparam int STEP_W     = $clog2(MUL_STEPS + 1);
  localparam int BIT_W      = $clog2(TERM_BITS + 1);

  localparam logic [0:0] REG_TEST_MINUS = 1'b0;
  localparam logic [0:0] REG_TEST_PLUS  = 1'b1;

  typedef struct packed {
    logic [PRIME_BITS-1:0] prime;
    logic [TERM_BITS-1:0]  base_x;
    logic [TERM_BITS-1:0]  exp_y;
  } xydt_in_t;

  typedef struct packed {
    logic minus_divides;
    logic plus_divides;
  } xydt_out_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_REDUCE,
    CMD_SQUARE,
    CMD_MULT,
    CMD_SWAP,
    CMD_FINISH
  } xydt_op_e;

  typedef struct packed {
    xydt_op_e op;
    logic     step_first;
    logic     bit_sel;
  } xydt_cmd_t;

  typedef struct packed {
    logic exp_bit;
    logic step_last;
    logic zero_mod;
  } xydt_stat_t;

endpackage

@@ src/xydt_datapath.sv @@
// Datapath: shift-and-add modular multiplier, exponent registers, result compare.
module xydt_datapath
  import xydt_pkg::*;
(
  input  logic       clk_i,
  input  xydt_in_t   item_i,
  input  logic       en_minus_i,
  input  logic       en_plus_i,
  input  xydt_cmd_t  cmd_i,
  output xydt_stat_t stat_o,
  output xydt_out_t  result_o
);

  logic [PRIME_BITS-1:0] mod_q, res_a_q, acc_q, base_q, mulb_q, prod_q, mul_a;
  logic [TERM_BITS-1:0]  exp_q, next_exp_q;
  logic [STEP_W-1:0]     step_q;
  logic [BIT_W-1:0]      ebit_q;
  logic [PRIME_BITS:0]   p2, p2r, p3, p3r;
  xydt_out_t             result_q;

  assign mul_a = (cmd_i.op == CMD_REDUCE) ? PRIME_BITS'(1) :
                 ((cmd_i.op == CMD_SQUARE) ? acc_q : base_q);

  always_comb begin
    p2  = {prod_q, 1'b0};
    p2r = (p2 >= {1'b0, mod_q}) ? p2 - {1'b0, mod_q} : p2;
    p3  = p2r + (mulb_q[PRIME_BITS-1] ? {1'b0, mul_a} : '0);
    p3r = (p3 >= {1'b0, mod_q}) ? p3 - {1'b0, mod_q} : p3;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        mod_q      <= item_i.prime;
        base_q     <= {{(PRIME_BITS-TERM_BITS){1'b0}}, item_i.base_x};
        exp_q      <= item_i.exp_y;
        next_exp_q <= item_i.base_x;
        acc_q      <= '0;
        ebit_q     <= BIT_W'(TERM_BITS - 1);
      end
      CMD_REDUCE, CMD_SQUARE, CMD_MULT: begin
        if (cmd_i.step_first) begin
          prod_q <= '0;
          step_q <= '0;
          mulb_q <= (cmd_i.op == CMD_REDUCE) ? base_q : acc_q;
        end else begin
          prod_q <= p3r[PRIME_BITS-1:0];
          mulb_q <= {mulb_q[PRIME_BITS-2:0], 1'b0};
          step_q <= step_q + STEP_W'(1);
          if (stat_o.step_last) begin
            if (cmd_i.op == CMD_REDUCE) begin
              base_q <= p3r[PRIME_BITS-1:0];
              acc_q  <= (mod_q == PRIME_BITS'(1)) ? '0 : PRIME_BITS'(1);
            end else begin
              acc_q <= p3r[PRIME_BITS-1:0];
              if (cmd_i.op == CMD_MULT || !cmd_i.bit_sel)
                ebit_q <= ebit_q - BIT_W'(1);
            end
          end
        end
      end
      CMD_SWAP: begin
        res_a_q <= acc_q;
        base_q  <= {{(PRIME_BITS-TERM_BITS){1'b0}}, exp_q};
        exp_q   <= next_exp_q;
        ebit_q  <= BIT_W'(TERM_BITS - 1);
      end
      CMD_FINISH: begin
        result_q.minus_divides <= !stat_o.zero_mod && en_minus_i && res_a_q == acc_q;
        result_q.plus_divides  <= !stat_o.zero_mod && en_plus_i && acc_q != '0 &&
                                  res_a_q == mod_q - acc_q;
      end
      default: ;
    endcase
  end

  assign stat_o.exp_bit   = exp_q[ebit_q[BIT_W-2:0]];
  assign stat_o.step_last = step_q == STEP_W'(MUL_STEPS - 1);
  assign stat_o.zero_mod  = mod_q == '0;
  assign result_o         = result_q;

endmodule

@@ src/xydt_ctrl.sv @@
// Controller: sequences reduce, square and multiply steps for both exponentiations.
module xydt_ctrl
  import xydt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  xydt_stat_t stat_i,
  output xydt_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_MULT   = 3'd3;
  localparam logic [2:0] S_SWAP   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]       state_q, state_d;
  logic             first_q, first_d, pass_q, pass_d;
  logic [BIT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    first_d    = first_q;
    pass_d     = pass_q;
    cnt_d      = cnt_q;
    cmd_o      = '{op: CMD_NONE, step_first: first_q, bit_sel: stat_i.exp_bit};
    done_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_REDUCE;
          first_d  = 1'b1;
          pass_d   = 1'b0;
        end
      end
      S_REDUCE, S_SQUARE, S_MULT: begin
        cmd_o.op = state_q == S_REDUCE ? CMD_REDUCE :
                   (state_q == S_SQUARE ? CMD_SQUARE : CMD_MULT);
        first_d = 1'b0;
        if (!first_q && stat_i.step_last) begin
          first_d = 1'b1;
          if (state_q == S_REDUCE) begin
            state_d = S_SQUARE;
            cnt_d   = BIT_W'(TERM_BITS);
          end else if (state_q == S_SQUARE && stat_i.exp_bit) begin
            state_d = S_MULT;
          end else begin
            cnt_d   = cnt_q - BIT_W'(1);
            state_d = (cnt_q == BIT_W'(1)) ? (pass_q ? S_FINISH : S_SWAP) : S_SQUARE;
          end
        end
      end
      S_SWAP: begin
        cmd_o.op = CMD_SWAP;
        pass_d   = 1'b1;
        first_d  = 1'b1;
        state_d  = S_REDUCE;
      end
      S_FINISH: begin
        cmd_o.op = CMD_FINISH;
        state_d  = S_OUT;
      end
      S_OUT: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b1;
      pass_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

@@ src/xy_yx_divisibility_test.sv @@
// Top level: APB registers, controller and datapath of the divisibility test.
// One beat is accepted when start is high and busy is low; its result
// appears on result_o with done_o high for one cycle, after the bit-serial modular
// multiplier that both exponentiations share has run one reduction, 32 squarings and
// one multiply per set exponent bit for each exponentiation. busy drops the cycle
// after done_o, so the next beat can be taken once busy is low. Results cannot be
// stalled.
module xy_yx_divisibility_test
  import xydt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  xydt_in_t    item_i,
  output logic        done_o,
  output xydt_out_t   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       en_minus_q, en_plus_q, wr;
  xydt_cmd_t  cmd;
  xydt_stat_t stat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_minus_q <= 1'b1;
      en_plus_q  <= 1'b1;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_TEST_MINUS) en_minus_q <= pwdata[0];
      if (paddr[2] == REG_TEST_PLUS)  en_plus_q  <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_TEST_MINUS: prdata[0] = en_minus_q;
      REG_TEST_PLUS:  prdata[0] = en_plus_q;
      default:        prdata    = '0;
    endcase
  end

  xydt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat),
    .cmd_o(cmd), .busy_o(busy), .done_o
  );

  xydt_datapath u_dp (
    .clk_i, .item_i, .en_minus_i(en_minus_q), .en_plus_i(en_plus_q),
    .cmd_i(cmd), .stat_o(stat), .result_o
  );

endmodule

@@ src/xydt_checker.sv @@
// Port-level checker for the divisibility test, bound to the top level.
module xydt_checker
  import xydt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input xydt_out_t result_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start not taken");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after done");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double done");
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done while idle");
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(result_o)) else $error("unknown result");

endmodule

bind xy_yx_divisibility_test xydt_checker u_chk (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the x^y / y^x divisibility test block.
module tb
  import xydt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  xydt_in_t    item_i = '0;
  logic        done_o;
  xydt_out_t   result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  xydt_out_t   verdict_q[$];
  logic        en_minus = 1'b1;
  logic        en_plus = 1'b1;
  int          errors = 0;
  int          sent = 0;

  localparam logic [63:0] PMASK = (64'd1 << PRIME_BITS) - 1;

  xy_yx_divisibility_test dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] t;
    t = a * b;
    return 64'(t % m);
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [31:0] e, logic [63:0] m);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd1 % m;
    b = base % m;
    for (int i = TERM_BITS - 1; i >= 0; i--) begin
      r = mul_mod(r, r, m);
      if (e[i]) r = mul_mod(r, b, m);
    end
    return r;
  endfunction

  function automatic xydt_out_t divisibility(xydt_in_t it);
    xydt_out_t   v;
    logic [63:0] p;
    logic [63:0] a;
    logic [63:0] b;
    v = '0;
    p = 64'(it.prime);
    if (p != 0) begin
      a = pow_mod(64'(it.base_x), it.exp_y, p);
      b = pow_mod(64'(it.exp_y), it.base_x, p);
      v.minus_divides = en_minus && (a == b);
      v.plus_divides  = en_plus && (b != 0) && (a == p - b);
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result %b", $time, result_o);
        errors++;
      end else begin
        xydt_out_t exp_v;
        exp_v = verdict_q.pop_front();
        if (exp_v.minus_divides !== result_o.minus_divides) begin
          $display("%0t: minus_divides expected %b actual %b", $time,
                   exp_v.minus_divides, result_o.minus_divides);
          errors++;
        end
        if (exp_v.plus_divides !== result_o.plus_divides) begin
          $display("%0t: plus_divides expected %b actual %b", $time,
                   exp_v.plus_divides, result_o.plus_divides);
          errors++;
        end
      end
    end
  end

  // hold start until the beat is taken; leave it high on return, but at random drop it and wait before returning
  task automatic send(logic [63:0] p, logic [31:0] x, logic [31:0] y);
    xydt_in_t it;
    it.prime  = p[PRIME_BITS-1:0];
    it.base_x = x;
    it.exp_y  = y;
    start  <= 1'b1;
    item_i <= it;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    verdict_q.push_back(divisibility(it));
    sent++;
    if (!(sent > 600 && sent < 1000) && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr[2] == REG_TEST_MINUS) en_minus = data[0];
    if (addr[2] == REG_TEST_PLUS) en_plus = data[0];
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[0] !== data[0]) begin
      $display("%0t: readback at %0d expected %b actual %b", $time, addr, data[0], prdata[0]);
      errors++;
    end
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_tests(logic m, logic p);
    drain();
    write_reg({REG_TEST_MINUS, 2'b00}, {31'd0, m});
    write_reg({REG_TEST_PLUS, 2'b00}, {31'd0, p});
  endtask

  task automatic test_directed();
    send(64'd3, 32'd2, 32'd1);
    send(64'd3, 32'd2, 32'd2);
    send(PMASK, 32'hffff_ffff, 32'hffff_ffff);
    send(PMASK, 32'd2, 32'hffff_fffe);
    send(64'd0, 32'd5, 32'd7);
    send(64'd1, 32'd5, 32'd7);
    send(64'd1, 32'd0, 32'd0);
    send(64'd10, 32'd3, 32'd4);
    send(64'd15, 32'd2, 32'd6);
    send(64'd7, 32'd49, 32'd21);
    send(64'd7, 32'd14, 32'd7);
    send(64'd5, 32'd0, 32'd3);
    send(64'd5, 32'd3, 32'd0);
    send(64'd11, 32'd0, 32'd0);
    send(64'd13, 32'd9, 32'd9);
    send(64'd5, 32'd2, 32'd3);
    send(64'd4611686018427387847, 32'd123457, 32'd98765);
    send(64'd2, 32'd3, 32'd5);
  endtask

  task automatic test_random(int n);
    logic [63:0] p;
    logic [31:0] x;
    logic [31:0] y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: p = {$urandom, $urandom} & PMASK;
        1: p = 64'($urandom_range(3, 200)) | 64'd1;
        2: p = 64'($urandom_range(3, 40000)) | 64'd1;
        default: p = 64'($urandom_range(0, 12));
      endcase
      x = ($urandom_range(1) != 0) ? $urandom : $urandom_range(0, 50);
      y = ($urandom_range(3) == 0) ? x : (($urandom_range(1) != 0) ? $urandom
                                                                   : $urandom_range(0, 50));
      send(p, x, y);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450);
    set_tests(1'b0, 1'b0);
    test_directed();
    test_random(400);
    set_tests(1'b1, 1'b0);
    test_random(420);
    set_tests(1'b0, 1'b1);
    test_random(420);
    set_tests(1'b1, 1'b1);
    test_random(30);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/xydt_pkg.sv
src/xydt_datapath.sv
src/xydt_ctrl.sv
src/xy_yx_divisibility_test.sv
src/xydt_checker.sv
tb/tb.sv
